// ===== src/dcst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcst_pkg
// Shared types, constants and helper functions for the dot column styler.
// ----------------------------------------------------------------------------
package dcst_pkg;

    localparam int DOTS       = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;
    localparam int STAGES     = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCRIPT_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EMPHASIS      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_MARKS    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_VIDEO = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSTRIKE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WIDTH  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONDENSED     = 4'd7;

    // script modes
    localparam logic [1:0] SCRIPT_SUPER = 2'd1;
    localparam logic [1:0] SCRIPT_SUB   = 2'd2;

    localparam logic [DOTS-1:0] UNDER_ROWS = 48'hE000_0000_0000;
    localparam logic [DOTS-1:0] OVER_ROWS  = 48'h0000_0000_0007;

    localparam logic [7:0] COND_MIN     = 8'd36;
    localparam logic [7:0] COND_LAST_IN = 8'd35;
    localparam int         COND_TOTAL   = 21;
    localparam int         SUB_SHIFT    = 20;
    localparam int         HL_ROWS      = 9;
    localparam int         HL_BYTES     = 6;

    typedef logic [DOTS-1:0] t_dots;

    typedef struct packed {
        logic [1:0] script_mode;
        logic       emphasis;
        logic [1:0] line_marks;
        logic       highlight;
        logic       reverse_video;
        logic       overstrike;
        logic       double_width;
        logic       condensed;
    } t_cfg;

    // up to four styled stage columns produced by one input item
    typedef struct packed {
        logic [STAGES-1:0][DOTS-1:0] cols;
        logic [STAGES-1:0]           fin;
        logic [1:0]                  first;
        logic [1:0]                  last;
        logic                        dbl;
    } t_bundle;

    // highlight pattern, nine rows of eight bytes
    localparam logic [7:0] HL_TABLE [HL_ROWS*8] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60,
        8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60, 8'h60,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h06, 8'h00, 8'h06, 8'h00, 8'h06, 8'h00, 8'h06, 8'h00,
        8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06, 8'h06,
        8'h00, 8'h06, 8'h00, 8'h06, 8'h00, 8'h06, 8'h00, 8'h06,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // keep even rows, packed into the lower half or shifted down for subscript
    function automatic t_dots half_rows(input t_dots c, input logic sub);
        logic [DOTS/2-1:0] h;
        for (int i = 0; i < DOTS/2; i++) begin
            h[i] = c[2*i];
        end
        return sub ? (t_dots'(h) << SUB_SHIFT) : t_dots'(h);
    endfunction

    // highlight mask for one pattern row, msb of each byte is the lowest numbered dot
    function automatic t_dots hl_mask(input logic [3:0] row);
        t_dots m;
        int    base;
        base = (row < 4'(HL_ROWS)) ? int'(row) * 8 : 0;
        m    = '0;
        for (int b = 0; b < HL_BYTES; b++) begin
            for (int k = 0; k < 8; k++) begin
                m[b*8+k] = HL_TABLE[base+b][7-k];
            end
        end
        return m;
    endfunction

endpackage

// ===== src/dcst_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcst_if
// Handshake channels of the dot column styler: columns in, columns out and
// configuration writes.
// ----------------------------------------------------------------------------
interface dcst_col_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] column;
    logic [7:0]  glyph_width;

    modport source (output valid, column, glyph_width, input ready);
    modport sink   (input valid, column, glyph_width, output ready);
endinterface

interface dcst_col_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] styled_column;
    logic        last_column;

    modport source (output valid, styled_column, last_column, input ready);
    modport sink   (input valid, styled_column, last_column, output ready);
endinterface

interface dcst_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dcst_pkg::CFG_IDX_W-1:0]   index;
    logic [dcst_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/dot_column_style_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_column_style_transform
// Styles the 48-dot columns of a printer glyph: condensed pairing, script
// halving, emphasis, line marks, highlight, reverse, double strike and
// double width.
//
//   channel | dir | payload                          | transfer when
//   i_col   | in  | column[47:0], glyph_width[7:0]   | valid && ready
//   o_col   | out | styled_column[47:0], last_column | valid && ready
//   i_cfg   | in  | index[3:0], data[7:0]            | valid && ready
//
// An input column is registered in the input register, styled in one
// pass into a bundle of up to four stage columns, then handed out one
// column per cycle from the result register while o_col is ready, each
// column twice in double width. The result register drain sets the rate.
// Reset (synchronous, active low) clears the glyph state and configuration.
// A stalled output keeps the bundle; the next input column is taken
// meanwhile and waits in the input register.
// ----------------------------------------------------------------------------
module dot_column_style_transform #(
    parameter int MAX_COLUMNS = 96
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dcst_col_in_if.sink     i_col,
    dcst_col_out_if.source  o_col,
    dcst_cfg_if.sink        i_cfg
);
    import dcst_pkg::*;

    t_cfg    cfg;
    t_bundle bundle;
    logic    load;
    logic    free;

    // configuration registers
    dcst_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // single pass styling
    dcst_styler #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_styler (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_col    (i_col),
        .i_free   (free),
        .o_load   (load),
        .o_bundle (bundle)
    );

    // result register and output sequencing
    dcst_drain u_drain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_bundle (bundle),
        .o_free   (free),
        .o_col    (o_col)
    );

endmodule

// ===== src/dcst_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcst_cfg_regs
// Style configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module dcst_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dcst_cfg_if.sink        i_cfg,
    output dcst_pkg::t_cfg  o_cfg
);
    import dcst_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SCRIPT_MODE:   n_cfg.script_mode   = i_cfg.data[1:0];
                REG_EMPHASIS:      n_cfg.emphasis      = i_cfg.data[0];
                REG_LINE_MARKS:    n_cfg.line_marks    = i_cfg.data[1:0];
                REG_HIGHLIGHT:     n_cfg.highlight     = i_cfg.data[0];
                REG_REVERSE_VIDEO: n_cfg.reverse_video = i_cfg.data[0];
                REG_OVERSTRIKE:    n_cfg.overstrike    = i_cfg.data[0];
                REG_DOUBLE_WIDTH:  n_cfg.double_width  = i_cfg.data[0];
                REG_CONDENSED:     n_cfg.condensed     = i_cfg.data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== src/dcst_styler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcst_styler
// Input register, glyph state and the styling logic that turns one input
// column into up to four styled stage columns in a single pass.
// ----------------------------------------------------------------------------
module dcst_styler #(
    parameter int MAX_COLUMNS = 96
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dcst_pkg::t_cfg    i_cfg,
    dcst_col_in_if.sink       i_col,
    input  logic              i_free,
    output logic              o_load,
    output dcst_pkg::t_bundle o_bundle
);
    import dcst_pkg::*;

    localparam int          OIW    = $clog2(MAX_COLUMNS + 1);
    localparam int          HALF   = MAX_COLUMNS / 2;
    localparam logic [7:0]  MAX_W  = 8'(MAX_COLUMNS);
    localparam logic [OIW:0] HALF_S = (OIW+1)'(HALF);
    localparam logic [OIW:0] MAX_S  = (OIW+1)'(MAX_COLUMNS);
    localparam logic [OIW:0] COND_S = (OIW+1)'(COND_TOTAL);

    // input register
    logic       r_in_valid;
    t_dots      r_in_col;
    logic [7:0] r_in_width;

    // glyph state
    t_dots          r_prev;
    t_dots          r_pair;
    logic [7:0]     r_ic;
    logic [OIW-1:0] r_oi;
    logic [3:0]     r_row;

    t_dots          n_prev;
    t_dots          n_pair;
    logic [7:0]     n_ic;
    logic [OIW-1:0] n_oi;
    logic [3:0]     n_row;

    logic                      cond_path;
    logic [OIW:0]              normal_total;
    logic [OIW:0]              total;
    logic [STAGES-1:0]         present;
    logic [STAGES-1:0]         valid_s;
    logic [STAGES-1:0]         emit;
    logic [STAGES-1:0]         fin;
    logic [STAGES-1:0][OIW:0]  s_idx;
    logic [STAGES-1:0][3:0]    row_k;
    logic [STAGES-1:0][DOTS-1:0] styled;
    t_dots                     raw0;
    t_dots                     c0;
    logic [2:0]                nvalid;
    logic [3:0]                row_sum;
    logic                      glyph_end;
    logic                      adv;
    logic [1:0]                first_i;
    logic [1:0]                last_i;

    // path selection and stage count
    always_comb begin
        cond_path    = i_cfg.condensed && (r_in_width >= COND_MIN);
        normal_total = (r_in_width < MAX_W) ? (OIW+1)'(r_in_width) : MAX_S;
        total        = cond_path ? COND_S : normal_total;
        glyph_end    = (r_in_width == 8'd0) ||
                       (({1'b0, r_ic} + 9'd1) >= {1'b0, r_in_width});

        present = '0;
        if (r_in_width != 8'd0) begin
            if (cond_path) begin
                present[0] = (r_ic < COND_MIN) && r_ic[0];
                present[1] = (r_ic == COND_LAST_IN);
                present[2] = (r_ic == COND_LAST_IN);
                present[3] = (r_ic == COND_LAST_IN);
            end else begin
                present[0] = {1'b0, r_ic} < 9'(normal_total);
            end
        end

        fin    = '0;
        fin[0] = !cond_path && (({1'b0, r_ic} + 9'd1) == 9'(normal_total));
        fin[3] = cond_path;

        raw0 = cond_path ? (r_pair | r_in_col) : r_in_col;
        if (i_cfg.script_mode == SCRIPT_SUPER) begin
            c0 = half_rows(raw0, 1'b0);
        end else if (i_cfg.script_mode == SCRIPT_SUB) begin
            c0 = half_rows(raw0, 1'b1);
        end else begin
            c0 = raw0;
        end
    end

    // per stage styling, the three condensed padding columns start from blank dots
    always_comb begin
        for (int k = 0; k < STAGES; k++) begin
            t_dots      c;
            t_dots      p;
            t_dots      e;
            logic [3:0] rs;
            s_idx[k]   = {1'b0, r_oi} + (OIW+1)'(k);
            valid_s[k] = present[k] && (s_idx[k] < total);
            rs         = r_row + 4'(k);
            row_k[k]   = (rs >= 4'(HL_ROWS)) ? rs - 4'(HL_ROWS) : rs;
            c          = (k == 0) ? c0 : '0;
            p          = (k == 0) ? r_prev : ((k == 1) ? c0 : '0);
            e          = c;
            if (i_cfg.emphasis && (s_idx[k] != '0)) begin
                e = e | p;
            end
            if (i_cfg.line_marks[0]) begin
                e = e | UNDER_ROWS;
            end
            if (i_cfg.line_marks[1]) begin
                e = e | OVER_ROWS;
            end
            if (i_cfg.highlight) begin
                e = e | hl_mask(row_k[k]);
            end
            if (i_cfg.reverse_video) begin
                e = ~e;
            end
            if (i_cfg.overstrike) begin
                e = e | (e << 1);
            end
            styled[k] = e;
            emit[k]   = valid_s[k] && !(i_cfg.double_width && (total > HALF_S) &&
                                        (s_idx[k] < total - HALF_S));
        end
    end

    // emitted range inside the bundle
    always_comb begin
        first_i = 2'd0;
        last_i  = 2'd0;
        for (int k = STAGES - 1; k >= 0; k--) begin
            if (emit[k]) begin
                first_i = 2'(k);
            end
        end
        for (int k = 0; k < STAGES; k++) begin
            if (emit[k]) begin
                last_i = 2'(k);
            end
        end
    end

    // handshake with the drain stage
    assign adv         = r_in_valid && ((emit == '0) || i_free);
    assign o_load      = adv && (emit != '0);
    assign i_col.ready = !r_in_valid || adv;

    always_comb begin
        o_bundle.cols  = styled;
        o_bundle.fin   = fin;
        o_bundle.first = first_i;
        o_bundle.last  = last_i;
        o_bundle.dbl   = i_cfg.double_width;
    end

    // glyph state update
    always_comb begin
        nvalid  = 3'(valid_s[0]) + 3'(valid_s[1]) + 3'(valid_s[2]) + 3'(valid_s[3]);
        row_sum = r_row + 4'(nvalid);
        n_prev  = r_prev;
        n_pair  = r_pair;
        n_ic    = r_ic + 8'd1;
        n_oi    = r_oi + OIW'(nvalid);
        n_row   = (row_sum >= 4'(HL_ROWS)) ? row_sum - 4'(HL_ROWS) : row_sum;
        if (valid_s[1]) begin
            n_prev = '0;
        end else if (valid_s[0]) begin
            n_prev = c0;
        end
        if (cond_path && (r_in_width != 8'd0) && (r_ic < COND_MIN) && !r_ic[0]) begin
            n_pair = r_in_col;
        end
        if (glyph_end) begin
            n_prev = '0;
            n_pair = '0;
            n_ic   = '0;
            n_oi   = '0;
            n_row  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_prev     <= '0;
            r_pair     <= '0;
            r_ic       <= '0;
            r_oi       <= '0;
            r_row      <= '0;
        end else begin
            if (i_col.valid && i_col.ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_prev <= n_prev;
                r_pair <= n_pair;
                r_ic   <= n_ic;
                r_oi   <= n_oi;
                r_row  <= n_row;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (i_col.valid && i_col.ready) begin
            r_in_col   <= i_col.column;
            r_in_width <= i_col.glyph_width;
        end
    end

endmodule

// ===== src/dcst_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcst_drain
// Result register holding one bundle of styled columns, handed out one
// column per transfer, each twice in double width.
// ----------------------------------------------------------------------------
module dcst_drain (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  dcst_pkg::t_bundle i_bundle,
    output logic              o_free,
    dcst_col_out_if.source    o_col
);
    import dcst_pkg::*;

    logic      r_valid;
    t_bundle   r_bundle;
    logic [1:0] r_ptr;
    logic      r_phase;

    logic out_xfer;
    logic col_end;
    logic done;

    assign out_xfer = r_valid && o_col.ready;
    assign col_end  = !r_bundle.dbl || r_phase;
    assign done     = out_xfer && col_end && (r_ptr == r_bundle.last);
    assign o_free   = !r_valid || done;

    assign o_col.valid         = r_valid;
    assign o_col.styled_column = r_bundle.cols[r_ptr];
    assign o_col.last_column   = r_valid && r_bundle.fin[r_ptr] && col_end;

    // bundle sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ptr   <= '0;
            r_phase <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_ptr   <= i_bundle.first;
            r_phase <= 1'b0;
        end else if (out_xfer) begin
            if (!col_end) begin
                r_phase <= 1'b1;
            end else begin
                r_phase <= 1'b0;
                if (r_ptr == r_bundle.last) begin
                    r_valid <= 1'b0;
                end else begin
                    r_ptr <= r_ptr + 2'd1;
                end
            end
        end
    end

    // bundle payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

// ===== src/dcst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcst_checker
// Port level checks of the dot column styler, bound to the top level.
// ----------------------------------------------------------------------------
module dcst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_out_col,
    input logic        i_out_last
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_col) && $stable(i_out_last))
        else $error("stalled output changed");

    // glyph end mark only on a real column
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_last |-> i_out_valid)
        else $error("last column without valid");

    // with nothing waiting on the output the input is never held off
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled while output idle");

endmodule

bind dot_column_style_transform dcst_checker u_dcst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_col.ready),
    .i_out_valid (o_col.valid),
    .i_out_ready (o_col.ready),
    .i_out_col   (o_col.styled_column),
    .i_out_last  (o_col.last_column)
);

// ===== sim/dcst_style_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcst_style_checker
// Watches the column and register channels of the dot column styler, keeps
// its own copy of the glyph state and settings, works out the styled columns
// each accepted input column should give and compares every output transfer
// with the oldest one still due.
// ----------------------------------------------------------------------------
module dcst_style_checker #(
    parameter int MAX_COLUMNS = 96
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    dcst_col_in_if  col_in,
    dcst_col_out_if col_out,
    dcst_cfg_if     cfg_in,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);
    import dcst_pkg::*;

    localparam int          PAIRED_INPUTS  = 36;
    localparam int          PAIRED_STAGES  = 21;
    localparam int          SUB_DROP       = 20;
    localparam logic [47:0] UNDERLINE_DOTS = 48'hE000_0000_0000;
    localparam logic [47:0] OVERLINE_DOTS  = 48'h0000_0000_0007;

    typedef struct packed {
        logic [47:0] dots;
        logic        last;
    } t_styled;

    t_styled     due_columns [$];

    // register copies
    logic [1:0]  script_sel;
    logic        emph_on;
    logic [1:0]  marks;
    logic        hilite_on;
    logic        rev_on;
    logic        strike_on;
    logic        wide_on;
    logic        cond_on;

    // glyph state
    logic [47:0] prev_dots;
    logic [47:0] pair_dots;
    int          in_count;
    int          stage_idx;

    // keep the even rows, packed low or moved down for subscript
    function automatic logic [47:0] squash_rows(input logic [47:0] c, input logic sub);
        logic [47:0] r;
        int          dst;
        r = '0;
        for (int row = 0; row < 48; row += 2) begin
            dst = row / 2 + (sub ? SUB_DROP : 0);
            if (c[row] && dst < 48) begin
                r[dst] = 1'b1;
            end
        end
        return r;
    endfunction

    // highlight dots for stage column s, msb of each pattern byte first
    function automatic logic [47:0] highlight_dots(input int s);
        logic [63:0] pattern;
        logic [47:0] m;
        case (s % 9)
            1, 2:    pattern = 64'h6060_6060_6060_6060;
            5:       pattern = 64'h0600_0600_0600_0600;
            6:       pattern = 64'h0606_0606_0606_0606;
            7:       pattern = 64'h0006_0006_0006_0006;
            default: pattern = '0;
        endcase
        for (int b = 0; b < 6; b++) begin
            for (int k = 0; k < 8; k++) begin
                m[b*8+k] = pattern[63-b*8-k];
            end
        end
        return m;
    endfunction

    task automatic clear_glyph();
        prev_dots = '0;
        pair_dots = '0;
        in_count  = 0;
        stage_idx = 0;
    endtask

    // style one stage column and queue the columns it gives
    task automatic emit_stage(input logic [47:0] raw, input int total, input logic fin);
        int          s;
        logic [47:0] c;
        logic [47:0] e;
        t_styled     item;
        s = stage_idx;
        if (s >= total) begin
            return;
        end
        stage_idx = stage_idx + 1;
        c = raw;
        if (script_sel == SCRIPT_SUPER) begin
            c = squash_rows(raw, 1'b0);
        end else if (script_sel == SCRIPT_SUB) begin
            c = squash_rows(raw, 1'b1);
        end
        e = c;
        if (emph_on && s > 0) begin
            e = e | prev_dots;
        end
        prev_dots = c;
        if (marks[0]) begin
            e = e | UNDERLINE_DOTS;
        end
        if (marks[1]) begin
            e = e | OVERLINE_DOTS;
        end
        if (hilite_on) begin
            e = e | highlight_dots(s);
        end
        if (rev_on) begin
            e = ~e;
        end
        if (strike_on) begin
            e = e | (e << 1);
        end
        item.dots = e;
        if (wide_on) begin
            // only the last half-capacity stage columns fit when doubled
            if (total > MAX_COLUMNS / 2 && s < total - MAX_COLUMNS / 2) begin
                return;
            end
            item.last   = 1'b0;
            due_columns = {due_columns, item};
            item.last   = fin;
            due_columns = {due_columns, item};
        end else begin
            item.last   = fin;
            due_columns = {due_columns, item};
        end
    endtask

    // work out the styled columns of one accepted input column
    task automatic style_glyph_column(input logic [47:0] col, input logic [7:0] w);
        int idx;
        int total;
        idx = in_count;
        if (w != 0) begin
            if (cond_on && w >= PAIRED_INPUTS) begin
                // condensed: pairs of inputs, three blanks after the last pair
                if (idx < PAIRED_INPUTS) begin
                    if (idx % 2 == 0) begin
                        pair_dots = col;
                    end else begin
                        emit_stage(pair_dots | col, PAIRED_STAGES, 1'b0);
                        if (idx == PAIRED_INPUTS - 1) begin
                            for (int k = 0; k < 3; k++) begin
                                emit_stage('0, PAIRED_STAGES, k == 2);
                            end
                        end
                    end
                end
            end else begin
                total = (w < MAX_COLUMNS) ? int'(w) : MAX_COLUMNS;
                if (idx < total) begin
                    emit_stage(col, total, idx + 1 == total);
                end
            end
        end
        // zero width or the glyph's last input closes the glyph
        if (w == 0 || idx + 1 >= w) begin
            clear_glyph();
        end else begin
            in_count = idx + 1;
        end
    endtask

    task automatic check_styled(input logic [47:0] dots, input logic last);
        t_styled want;
        o_checked++;
        if (due_columns.size() == 0) begin
            o_fail_count++;
            $error("styled_column: expected none, got %h (last_column %b)", dots, last);
        end else begin
            want = due_columns.pop_front();
            if (dots !== want.dots) begin
                o_fail_count++;
                $error("styled_column: expected %h, got %h", want.dots, dots);
            end
            if (last !== want.last) begin
                o_fail_count++;
                $error("last_column: expected %b, got %b", want.last, last);
            end
        end
    endtask

    // compare before predicting: an input transfer cannot come out on its own edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            script_sel = '0;
            emph_on    = 1'b0;
            marks      = '0;
            hilite_on  = 1'b0;
            rev_on     = 1'b0;
            strike_on  = 1'b0;
            wide_on    = 1'b0;
            cond_on    = 1'b0;
            clear_glyph();
            due_columns.delete();
        end else begin
            if (col_out.valid && col_out.ready) begin
                check_styled(col_out.styled_column, col_out.last_column);
            end
            if (cfg_in.valid && cfg_in.ready) begin
                case (cfg_in.index)
                    REG_SCRIPT_MODE:   script_sel = cfg_in.data[1:0];
                    REG_EMPHASIS:      emph_on    = cfg_in.data[0];
                    REG_LINE_MARKS:    marks      = cfg_in.data[1:0];
                    REG_HIGHLIGHT:     hilite_on  = cfg_in.data[0];
                    REG_REVERSE_VIDEO: rev_on     = cfg_in.data[0];
                    REG_OVERSTRIKE:    strike_on  = cfg_in.data[0];
                    REG_DOUBLE_WIDTH:  wide_on    = cfg_in.data[0];
                    REG_CONDENSED:     cond_on    = cfg_in.data[0];
                    default: ;
                endcase
            end
            if (col_in.valid && col_in.ready) begin
                style_glyph_column(col_in.column, col_in.glyph_width);
            end
        end
        o_pending = due_columns.size();
    end

endmodule

// ===== sim/tb_dot_column_style_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dot_column_style_transform
// Drives glyph columns and register settings into the dot column styler: a
// short directed pass over the corner cases, then phases of random glyphs
// under changing settings and idling, with a long output hold and a mid-glyph
// drain. The checker beside the block does the comparing; this module makes
// stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_dot_column_style_transform;
    import dcst_pkg::*;

    localparam int         MAX_COLUMNS    = 96;
    localparam int         PHASES         = 8;
    localparam int         PHASE_BUDGET   = 10;
    localparam int         SETTLE_CYCLES  = 20;
    localparam int         HOLD_CYCLES    = 80;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam logic [1:0] SCRIPT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [1:0] script;
        logic       emph;
        logic [1:0] marks;
        logic       hilite;
        logic       rev;
        logic       strike;
        logic       wide;
        logic       cond;
    } t_style;

    logic i_clk;
    logic i_rst_n;
    logic hold_req = 1'b0;
    int   fail_count;
    int   pending;
    int   checked;
    int   tx_idle_pct;
    int   rx_stall_pct;
    int   sent_columns;
    int   settings_done;
    int   quiet_cycles;

    dcst_col_in_if  col_if ();
    dcst_col_out_if out_if ();
    dcst_cfg_if     cfg_if ();

    dot_column_style_transform #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) dut (
        .i_clk,
        .i_rst_n,
        .i_col(col_if),
        .o_col(out_if),
        .i_cfg(cfg_if)
    );

    dcst_style_checker #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_checker (
        .i_clk,
        .i_rst_n,
        .col_in(col_if),
        .col_out(out_if),
        .cfg_in(cfg_if),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_checked(checked)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // output side: random stalls, or a long hold when asked
    initial begin
        bit grab;
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            grab = hold_req;
            if (grab) begin
                hold_req = 1'b0;
            end
            @(negedge i_clk);
            if (grab) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((col_if.valid && col_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d columns still due",
                     quiet_cycles, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [47:0] random_dots();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return r[47:0];
        endcase
    endfunction

    function automatic logic [7:0] small_width();
        if ($urandom_range(0, 4) == 0) begin
            return 8'($urandom_range(9, 30));
        end
        return 8'($urandom_range(1, 8));
    endfunction

    function automatic t_style random_style();
        t_style st;
        st.script = 2'($urandom_range(0, 3));
        st.emph   = 1'($urandom_range(0, 1));
        st.marks  = 2'($urandom_range(0, 3));
        st.hilite = 1'($urandom_range(0, 1));
        st.rev    = 1'($urandom_range(0, 1));
        st.strike = 1'($urandom_range(0, 1));
        st.wide   = 1'($urandom_range(0, 1));
        st.cond   = 1'($urandom_range(0, 1));
        return st;
    endfunction

    // one column transfer; entered and left at a falling edge, valid left high
    task automatic send_column(input logic [47:0] dots, input logic [7:0] w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            col_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        col_if.valid       <= 1'b1;
        col_if.column      <= dots;
        col_if.glyph_width <= w;
        @(posedge i_clk);
        while (col_if.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        sent_columns++;
    endtask

    // one register transfer; the caller lowers valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_style(input t_style st);
        write_reg(REG_SCRIPT_MODE, 8'(st.script));
        write_reg(REG_EMPHASIS, 8'(st.emph));
        write_reg(REG_LINE_MARKS, 8'(st.marks));
        write_reg(REG_HIGHLIGHT, 8'(st.hilite));
        write_reg(REG_REVERSE_VIDEO, 8'(st.rev));
        write_reg(REG_OVERSTRIKE, 8'(st.strike));
        write_reg(REG_DOUBLE_WIDTH, 8'(st.wide));
        write_reg(REG_CONDENSED, 8'(st.cond));
        cfg_if.valid <= 1'b0;
        settings_done++;
    endtask

    // stop offering, wait for every due column, then let the pipeline settle
    task automatic wait_drained();
        col_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // a glyph of random columns, optionally with stray widths mixed in
    task automatic send_random_glyph(input logic [7:0] w, input logic noisy, input int pause_at);
        logic [7:0] wi;
        for (int i = 0; i < w; i++) begin
            if (i == pause_at) begin
                wait_drained();
            end
            wi = w;
            if (noisy && $urandom_range(0, 99) < 5) begin
                wi = 8'($urandom_range(0, 255));
            end
            send_column(random_dots(), wi);
        end
    endtask

    initial begin
        t_style st;
        int     budget;
        col_if.valid       = 1'b0;
        col_if.column      = '0;
        col_if.glyph_width = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        tx_idle_pct        = 0;
        rx_stall_pct       = 0;
        i_rst_n            = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: blank, solid and striped columns
        send_column('0, 8'd3);
        send_column('1, 8'd3);
        send_column(48'hAAAA_AAAA_AAAA, 8'd3);
        // zero width emits nothing and closes the glyph
        send_column('1, 8'd0);
        // widest glyph cut short by a width change mid-glyph
        send_column(48'h0000_0000_0001, 8'd255);
        send_column(48'h8000_0000_0000, 8'd255);
        send_column(48'h5555_5555_5555, 8'd2);
        wait_drained();

        // every style but condensed at once, superscript
        st        = '0;
        st.script = SCRIPT_SUPER;
        st.emph   = 1'b1;
        st.marks  = 2'b11;
        st.hilite = 1'b1;
        st.rev    = 1'b1;
        st.strike = 1'b1;
        st.wide   = 1'b1;
        apply_style(st);
        for (int i = 0; i < 4; i++) begin
            send_column(random_dots(), 8'd4);
        end
        wait_drained();

        // subscript with emphasis, underline and overstrike
        st        = '0;
        st.script = SCRIPT_SUB;
        st.emph   = 1'b1;
        st.marks  = 2'b01;
        st.strike = 1'b1;
        apply_style(st);
        send_column('1, 8'd3);
        send_column(48'h0F0F_0F0F_0F0F, 8'd3);
        send_column(48'hFFFF_0000_FFFF, 8'd3);
        wait_drained();

        // unused script mode, overline, highlight pattern wrapping past nine
        st        = '0;
        st.script = SCRIPT_UNUSED;
        st.marks  = 2'b10;
        st.hilite = 1'b1;
        apply_style(st);
        for (int i = 0; i < 10; i++) begin
            send_column(random_dots(), 8'd10);
        end

        // random phases under changing settings and idling
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            st = random_style();
            if (p == 0) begin
                st        = '1;
                st.script = SCRIPT_SUB;
            end
            if (p == 1) begin
                st = '0;
            end
            if (p == 3) begin
                st.script = SCRIPT_UNUSED;
            end
            if (p == 2) begin
                st.cond = 1'b1;
                st.wide = 1'b1;
            end
            if (p == 5) begin
                st.cond = 1'b1;
            end
            if (p == 6) begin
                st.cond = 1'b0;
                st.wide = 1'b1;
            end
            apply_style(st);
            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 57;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 57;
                end
                default: begin
                    tx_idle_pct  = 36;
                    rx_stall_pct = 36;
                end
            endcase
            budget = sent_columns + PHASE_BUDGET;
            while (sent_columns < budget) begin
                send_random_glyph(small_width(), 1'b1, -1);
            end
            // condensed glyph while the output is held off
            if (p == 2) begin
                hold_req = 1'b1;
                send_random_glyph(8'($urandom_range(36, 44)), 1'b0, -1);
            end
            // condensed glyph with the sender pausing until all is out
            if (p == 5) begin
                send_random_glyph(8'($urandom_range(36, 44)), 1'b0, 20);
            end
            // overlong glyph in double width
            if (p == 6) begin
                send_random_glyph(8'($urandom_range(97, 100)), 1'b0, -1);
            end
        end
        wait_drained();

        $display("run covered %0d input columns and %0d styled columns", sent_columns, checked);
        $display("over %0d register settings and four idling mixes", settings_done);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== dot_column_style_transform.f =====
src/dcst_pkg.sv
src/dcst_if.sv
src/dcst_cfg_regs.sv
src/dcst_styler.sv
src/dcst_drain.sv
src/dot_column_style_transform.sv
src/dcst_checker.sv
sim/dcst_style_checker.sv
sim/tb_dot_column_style_transform.sv
